// ----- src/dec_pkg.sv -----
`timescale 1ns / 1ps

package dec_pkg;

    // array geometry (depth is a power of two, index is a part-select of the address)
    localparam int MEM_DEPTH  = 1024;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int ADDR_REG_W = 10;
    localparam int DATA_W     = 8;
    localparam int CNT_W      = 16;

    localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [DATA_W-1:0] ERASED_VAL = 8'hFF;

    // bus access codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // register selects
    localparam logic [2:0] SEL_ADDR_LO = 3'd0;
    localparam logic [2:0] SEL_ADDR_HI = 3'd1;
    localparam logic [2:0] SEL_DATA    = 3'd2;
    localparam logic [2:0] SEL_CTRL    = 3'd3;
    localparam logic [2:0] SEL_UNLOCK  = 3'd4;

    // unlock sequence
    localparam logic [7:0] UNLOCK_KEY1 = 8'h55;
    localparam logic [7:0] UNLOCK_KEY2 = 8'hAA;
    localparam logic [1:0] UNLOCK_IDLE  = 2'd0;
    localparam logic [1:0] UNLOCK_FIRST = 2'd1;
    localparam logic [1:0] UNLOCK_ARMED = 2'd2;

    // default erase/write duration in ticks
    localparam logic [CNT_W-1:0] DURATION_RST = 16'd4000;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } state_t;

endpackage

// ----- src/dec_ram.sv -----
`timescale 1ns / 1ps

module dec_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- src/data_eeprom_controller_core.sv -----
`timescale 1ns / 1ps
// results: done strobes in the cycle after a transaction is accepted; a control write whose
//   RD bit loads the data register from the array sets done from the ST_READ state instead
// throughput: one transaction per cycle while busy is low; an array load holds busy through
//   ST_READ (single ram port with a registered read); the receiver cannot stall, results are never held
// reset: registers clear (dur_reg loads DURATION_RST), then a clearing pass writes 0xFF to all
//   MEM_DEPTH (1024) array bytes while busy is high; configuration writes are taken throughout

module data_eeprom_controller_core
    import dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [2:0]        reg_select,
    input  logic [7:0]        write_data,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    output logic              done,
    output logic [7:0]        read_data,
    output logic              write_busy
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [ADDR_REG_W-1:0] addr_reg, addr_next;
    logic [DATA_W-1:0]     data_reg, data_next;
    logic                  pgd_reg, pgd_next;
    logic                  cfgs_reg, cfgs_next;
    logic                  wren_reg, wren_next;
    logic                  wact_reg, wact_next;
    logic [1:0]            unlock_reg, unlock_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      dur_reg;

    logic                  done_reg, done_next;
    logic [7:0]            rdata_out_reg, rdata_out_next;
    logic                  wbusy_reg, wbusy_next;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [DATA_W-1:0]     mem_wdata;
    logic [DATA_W-1:0]     mem_rdata;

    logic                  accept;
    logic                  load_rd;
    logic                  data_space;
    logic [CNT_W-1:0]      cnt_dec;
    logic [7:0]            rd_val;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // array
    dec_ram #(
        .DEPTH (MEM_DEPTH),
        .AW    (ADDR_W),
        .DW    (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // access decode and next state
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        pgd_next       = pgd_reg;
        cfgs_next      = cfgs_reg;
        wren_next      = wren_reg;
        wact_next      = wact_reg;
        unlock_next    = unlock_reg;
        cnt_next       = cnt_reg;
        done_next      = 1'b0;
        rdata_out_next = rdata_out_reg;
        wbusy_next     = wbusy_reg;
        mem_we         = 1'b0;
        mem_addr       = addr_reg[ADDR_W-1:0];
        mem_wdata      = data_reg;
        load_rd        = 1'b0;
        data_space     = 1'b0;
        cnt_dec        = cnt_reg;
        rd_val         = 8'd0;

        case (state_reg)
            ST_CLEAR:
            begin
                // erase sweep after reset
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = ERASED_VAL;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_READ:
                        begin
                            case (reg_select)
                                SEL_ADDR_LO: rd_val = addr_reg[7:0];
                                SEL_ADDR_HI: rd_val = {6'd0, addr_reg[9:8]};
                                SEL_DATA:    rd_val = data_reg;
                                SEL_CTRL:    rd_val = {pgd_reg, cfgs_reg, 3'd0,
                                                       wren_reg, wact_reg, 1'b0};
                                default:     rd_val = 8'd0;
                            endcase
                            unlock_next = UNLOCK_IDLE;
                        end

                        OP_WRITE:
                        begin
                            unlock_next = UNLOCK_IDLE;
                            case (reg_select)
                                SEL_UNLOCK:
                                begin
                                    if (write_data == UNLOCK_KEY1)
                                    begin
                                        unlock_next = UNLOCK_FIRST;
                                    end
                                    else if (write_data == UNLOCK_KEY2 &&
                                             unlock_reg == UNLOCK_FIRST)
                                    begin
                                        unlock_next = UNLOCK_ARMED;
                                    end
                                end
                                SEL_ADDR_LO:
                                begin
                                    if (!wact_reg)
                                    begin
                                        addr_next[7:0] = write_data;
                                    end
                                end
                                SEL_ADDR_HI:
                                begin
                                    if (!wact_reg)
                                    begin
                                        addr_next[9:8] = write_data[1:0];
                                    end
                                end
                                SEL_DATA:
                                begin
                                    if (!wact_reg)
                                    begin
                                        data_next = write_data;
                                    end
                                end
                                SEL_CTRL:
                                begin
                                    // space selects are frozen while a write cycle is active
                                    if (!wact_reg)
                                    begin
                                        pgd_next  = write_data[7];
                                        cfgs_next = write_data[6];
                                    end
                                    wren_next  = write_data[2];
                                    data_space = !pgd_next && !cfgs_next;
                                    if (write_data[0] && !wact_reg && data_space)
                                    begin
                                        load_rd = 1'b1;
                                    end
                                    if (write_data[1] && !wact_reg && data_space &&
                                        wren_next && unlock_reg == UNLOCK_ARMED)
                                    begin
                                        wact_next = 1'b1;
                                        cnt_next  = (dur_reg == '0) ? CNT_W'(1) : dur_reg;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end

                        OP_TICK:
                        begin
                            // countdown and commit of the current address and data
                            if (wact_reg)
                            begin
                                cnt_dec  = (cnt_reg != '0) ? cnt_reg - 1'b1 : cnt_reg;
                                cnt_next = cnt_dec;
                                if (cnt_dec == '0)
                                begin
                                    mem_we    = 1'b1;
                                    wact_next = 1'b0;
                                end
                            end
                        end

                        default:
                        begin
                        end
                    endcase

                    rdata_out_next = rd_val;
                    wbusy_next     = wact_next;
                    if (load_rd)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end

            ST_READ:
            begin
                // array byte arrives in the cycle after the read
                data_next  = mem_rdata;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            addr_reg      <= '0;
            data_reg      <= '0;
            pgd_reg       <= 1'b0;
            cfgs_reg      <= 1'b0;
            wren_reg      <= 1'b0;
            wact_reg      <= 1'b0;
            unlock_reg    <= UNLOCK_IDLE;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            rdata_out_reg <= '0;
            wbusy_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            addr_reg      <= addr_next;
            data_reg      <= data_next;
            pgd_reg       <= pgd_next;
            cfgs_reg      <= cfgs_next;
            wren_reg      <= wren_next;
            wact_reg      <= wact_next;
            unlock_reg    <= unlock_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            rdata_out_reg <= rdata_out_next;
            wbusy_reg     <= wbusy_next;
        end
    end

    // duration register from the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg <= DURATION_RST;
        end
        else if (cfg_wr_en)
        begin
            dur_reg <= cfg_wr_data;
        end
    end

    assign done       = done_reg;
    assign read_data  = rdata_out_reg;
    assign write_busy = wbusy_reg;

endmodule
